### hdl/hrc_pkg.sv
// shared types, widths and fixed-point constants for the humidity converter
package hrc_pkg;

  // command codes
  localparam logic CMD_REL2ABS = 1'b0;
  localparam logic CMD_ABS2REL = 1'b1;

  // fixed-point constants
  localparam logic [20:0] MAGNUS_A = 21'd1154744;   // 17.62 in Q16
  localparam logic [16:0] MAGNUS_B = 17'd62239;     // 243.12 in Q8
  localparam logic [16:0] LOG2E    = 17'd94548;     // log2(e) in Q16
  localparam logic [29:0] LN2      = 30'd744261118; // ln 2 in Q30
  localparam logic [30:0] ONE30    = 31'h4000_0000; // 1.0 in Q30
  localparam logic [19:0] COEF     = 20'd868005;    // 216.7*6.112/100 in Q16
  localparam logic [16:0] KELVIN   = 17'd69926;     // 273.15 in Q8
  localparam logic [15:0] OUT_MAX  = 16'hFFFF;
  localparam int          K_BIAS   = 22;

  // widths along the datapath
  localparam int X_N_W   = 36;  // |t| * 17.62
  localparam int X_D_W   = 17;  // 243.12 + t
  localparam int X_Q_W   = 22;  // |x|
  localparam int X_W     = 23;  // signed x
  localparam int Y_W     = 23;  // signed y
  localparam int K_W     = 7;   // signed exponent
  localparam int Z_W     = 30;
  localparam int M_W     = 31;  // mantissa, Q30 in [1,2)
  localparam int S_W     = 6;   // final shift 14..51
  localparam int F_N_W   = 84;
  localparam int F_D_W   = 35;
  localparam int F_Q_W   = 36;
  localparam int EXP_LAT = 18;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] temperature;
    logic [15:0]        humidity_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] humidity_out;
    logic        saturated;
  } out_item_t;

  // item fields carried alongside the exponential
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] temp;
    logic [15:0]        hum;
  } front_sb_t;

  typedef struct packed {
    logic      neg;
    front_sb_t item;
  } xdiv_sb_t;

  typedef struct packed {
    logic           cmd;
    logic [S_W-1:0] shift;
    logic           sat;
  } fdiv_sb_t;

endpackage

### hdl/hrc_div.sv
// pipelined restoring divider, one quotient bit per stage
module hrc_div #(
  parameter int N_W  = 36,
  parameter int D_W  = 17,
  parameter int Q_W  = 22,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [N_W-1:0]  in_num,
  input  logic [D_W-1:0]  in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [Q_W-1:0]  out_quo,
  output logic [SB_W-1:0] out_sb
);

  logic            vld_r [0:Q_W];
  logic [D_W-1:0]  rem_r [0:Q_W];
  logic [Q_W-1:0]  low_r [0:Q_W];
  logic [Q_W-1:0]  quo_r [0:Q_W];
  logic [D_W-1:0]  den_r [0:Q_W];
  logic [SB_W-1:0] sb_r  [0:Q_W];
  logic [N_W-1:0]  top_nxt;

  // caller keeps num below den * 2^Q_W, so the upper part fits the remainder
  assign top_nxt = in_num >> Q_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= top_nxt[D_W-1:0];
    low_r[0] <= in_num[Q_W-1:0];
    quo_r[0] <= '0;
    den_r[0] <= in_den;
    sb_r[0]  <= in_sb;
  end

  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    logic [D_W:0]   trial_nxt;
    logic [D_W:0]   diff_nxt;
    logic           ge_nxt;

    // shift in next numerator bit, subtract when it fits
    assign trial_nxt = {rem_r[i-1], low_r[i-1][Q_W-1]};
    assign ge_nxt    = trial_nxt >= {1'b0, den_r[i-1]};
    assign diff_nxt  = trial_nxt - {1'b0, den_r[i-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge_nxt ? diff_nxt[D_W-1:0] : trial_nxt[D_W-1:0];
      low_r[i] <= low_r[i-1] << 1;
      quo_r[i] <= (quo_r[i-1] << 1) | Q_W'(ge_nxt);
      den_r[i] <= den_r[i-1];
      sb_r[i]  <= sb_r[i-1];
    end
  end

  assign out_valid = vld_r[Q_W];
  assign out_quo   = quo_r[Q_W];
  assign out_sb    = sb_r[Q_W];

endmodule

### hdl/hrc_exp.sv
// exp(x) pipeline: base-2 split, then an 8-term Horner series on the fraction
module hrc_exp import hrc_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [X_W-1:0] in_x,
  input  logic [SB_W-1:0]       in_sb,
  output logic                  out_valid,
  output logic signed [K_W-1:0] out_k,
  output logic [M_W-1:0]        out_m,
  output logic [SB_W-1:0]       out_sb
);

  typedef struct packed {
    logic [Z_W-1:0]        z;
    logic signed [K_W-1:0] k;
    logic [SB_W-1:0]       sb;
  } carry_t;

  logic                  y_valid_r;
  logic signed [Y_W-1:0] y_r;
  logic [SB_W-1:0]       y_sb_r;
  logic signed [40:0]    y_prod_nxt;

  logic                  z_valid_r;
  carry_t                z_r;
  logic [45:0]           z_prod_nxt;

  logic                  vm_r [0:7];
  logic [M_W-1:0]        mv_r [0:7];
  carry_t                cm_r [0:7];
  logic                  vp_r [0:7];
  logic [M_W-1:0]        pp_r [0:7];
  carry_t                cp_r [0:7];

  // y = x * log2(e), floored
  assign y_prod_nxt = 41'(in_x) * $signed(41'(LOG2E));

  // z = fraction of y scaled by ln 2
  assign z_prod_nxt = 46'(y_r[15:0]) * 46'(LN2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
      z_valid_r <= 1'b0;
    end else begin
      y_valid_r <= in_valid;
      z_valid_r <= y_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    y_r    <= y_prod_nxt[38:16];
    y_sb_r <= in_sb;
    z_r.z  <= z_prod_nxt[45:16];
    z_r.k  <= y_r[Y_W-1:16];
    z_r.sb <= y_sb_r;
  end

  // Horner steps, divisor 8 down to 1: multiply stage then divide stage
  for (genvar j = 0; j < 8; j++) begin : g_horner
    localparam int          N   = 8 - j;
    localparam int          L   = $clog2(N);
    localparam int          S   = M_W + L;
    localparam logic [32:0] MAG = 33'(((64'd1 << S) + 64'(N) - 64'd1) / 64'(N));

    logic [M_W-1:0]  p_in;
    carry_t          c_in;
    logic            v_in;
    logic [60:0]     pz_nxt;
    logic [65:0]     q_prod_nxt;

    if (j == 0) begin : g_first
      assign p_in = ONE30;
      assign c_in = z_r;
      assign v_in = z_valid_r;
    end else begin : g_next
      assign p_in = pp_r[j-1];
      assign c_in = cp_r[j-1];
      assign v_in = vp_r[j-1];
    end

    assign pz_nxt     = 61'(p_in) * 61'(c_in.z);
    // exact division by the step constant through a reciprocal
    assign q_prod_nxt = 66'(mv_r[j]) * 66'(MAG);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vm_r[j] <= 1'b0;
        vp_r[j] <= 1'b0;
      end else begin
        vm_r[j] <= v_in;
        vp_r[j] <= vm_r[j];
      end
    end

    always_ff @(posedge clk) begin
      mv_r[j] <= pz_nxt[60:30];
      cm_r[j] <= c_in;
      pp_r[j] <= ONE30 + q_prod_nxt[S +: M_W];
      cp_r[j] <= cm_r[j];
    end
  end

  assign out_valid = vp_r[7];
  assign out_m     = pp_r[7];
  assign out_k     = cp_r[7].k;
  assign out_sb    = cp_r[7].sb;

endmodule

### hdl/humidity_rel_abs_converter.sv
// humidity converter top: Magnus exponent divide, exp pipeline, scaling and final divide
// throughput: one item per cycle; busy stays low, the pipeline never stalls
// the pipeline depth is set by the two bit-per-stage dividers (23 and 37 stages) and the
// 18-stage exp pipeline; the receiver cannot stall, each result shows for one cycle
// reset (rst_n low, synchronous) clears every valid bit; items in flight are dropped
module humidity_rel_abs_converter import hrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int LAT = 2 + (X_Q_W + 1) + EXP_LAT + 2 + (F_Q_W + 1) + 1;

  // input register
  logic     a_valid_r;
  in_item_t a_item_r;

  // exponent numerator stage
  logic               b_valid_r;
  logic [X_N_W-1:0]   b_num_r;
  logic [X_D_W-1:0]   b_den_r;
  xdiv_sb_t           b_sb_r;
  logic signed [16:0] t_ext_nxt;
  logic [16:0]        t_mag_nxt;
  logic [17:0]        xden_nxt;

  // exponent divider output
  logic                  xq_valid;
  logic [X_Q_W-1:0]      xq;
  xdiv_sb_t              xq_sb;
  logic signed [X_W-1:0] x_nxt;

  // exp output
  logic                  e_valid;
  logic signed [K_W-1:0] e_k;
  logic [M_W-1:0]        e_m;
  front_sb_t             e_sb;

  // scaling stage one
  logic             p1_valid_r;
  logic [30:0]      p1_hm_r;
  logic [F_D_W-1:0] p1_cm_r;
  logic [32:0]      p1_num_r;
  logic [16:0]      p1_d_r;
  logic [S_W-1:0]   p1_shift_r;
  logic             p1_cmd_r;
  logic [46:0]      hm_prod_nxt;
  logic [50:0]      cm_prod_nxt;
  logic [17:0]      d_nxt;
  logic [7:0]       shift_nxt;

  // scaling stage two
  logic             p2_valid_r;
  logic [50:0]      p2_a_r;
  logic [F_N_W-1:0] p2_nsh_r;
  logic [F_D_W-1:0] p2_den_r;
  logic [16:0]      p2_d_r;
  logic [S_W-1:0]   p2_shift_r;
  logic             p2_cmd_r;

  // final divider
  logic             fin_sat_nxt;
  logic [F_N_W-1:0] fin_num_nxt;
  logic [F_D_W-1:0] fin_den_nxt;
  fdiv_sb_t         fin_sb_nxt;
  logic             fq_valid;
  logic [F_Q_W-1:0] fq;
  fdiv_sb_t         fq_sb;
  logic [F_Q_W-1:0] r0_nxt;
  out_item_t        out_nxt;

  logic      out_valid_r;
  out_item_t out_item_r;

  assign busy = 1'b0;

  // valid chain of the top-level stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= start;
      b_valid_r   <= a_valid_r;
      p1_valid_r  <= e_valid;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= fq_valid;
    end
  end

  // magnitude of 17.62*t and the divisor 243.12+t
  assign t_ext_nxt = 17'(a_item_r.temperature);
  assign t_mag_nxt = a_item_r.temperature[15] ? 17'(-t_ext_nxt) : 17'(t_ext_nxt);
  assign xden_nxt  = 18'(a_item_r.temperature) + 18'(MAGNUS_B);

  always_ff @(posedge clk) begin
    a_item_r      <= in_item;
    b_num_r       <= X_N_W'(t_mag_nxt) * X_N_W'(MAGNUS_A);
    b_den_r       <= xden_nxt[X_D_W-1:0];
    b_sb_r.neg    <= a_item_r.temperature[15];
    b_sb_r.item.cmd  <= a_item_r.cmd;
    b_sb_r.item.temp <= a_item_r.temperature;
    b_sb_r.item.hum  <= a_item_r.humidity_in;
  end

  hrc_div #(
    .N_W  (X_N_W),
    .D_W  (X_D_W),
    .Q_W  (X_Q_W),
    .SB_W ($bits(xdiv_sb_t))
  ) u_xdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid_r),
    .in_num    (b_num_r),
    .in_den    (b_den_r),
    .in_sb     (b_sb_r),
    .out_valid (xq_valid),
    .out_quo   (xq),
    .out_sb    (xq_sb)
  );

  // quotient truncated toward zero, sign restored
  assign x_nxt = xq_sb.neg ? X_W'(0) - X_W'(xq) : X_W'(xq);

  hrc_exp #(
    .SB_W ($bits(front_sb_t))
  ) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (xq_valid),
    .in_x      (x_nxt),
    .in_sb     (xq_sb.item),
    .out_valid (e_valid),
    .out_k     (e_k),
    .out_m     (e_m),
    .out_sb    (e_sb)
  );

  // scale by mantissa, kelvin divisor, shift from the exponent
  assign hm_prod_nxt = 47'(e_sb.hum) * 47'(e_m);
  assign cm_prod_nxt = 51'(COEF) * 51'(e_m);
  assign d_nxt       = 18'(e_sb.temp) + 18'(KELVIN);
  assign shift_nxt   = 8'(K_BIAS) - 8'(e_k);

  always_ff @(posedge clk) begin
    p1_hm_r    <= hm_prod_nxt[46:16];
    p1_cm_r    <= cm_prod_nxt[50:16];
    p1_num_r   <= 33'(e_sb.hum) * 33'(d_nxt[16:0]);
    p1_d_r     <= d_nxt[16:0];
    p1_shift_r <= shift_nxt[S_W-1:0];
    p1_cmd_r   <= e_sb.cmd;
    p2_a_r     <= 51'(p1_hm_r) * 51'(COEF);
    p2_nsh_r   <= F_N_W'(p1_num_r) << p1_shift_r;
    p2_den_r   <= p1_cm_r;
    p2_d_r     <= p1_d_r;
    p2_shift_r <= p1_shift_r;
    p2_cmd_r   <= p1_cmd_r;
  end

  // overflow test for absolute to relative, divider operand select
  assign fin_sat_nxt    = p2_nsh_r >= F_N_W'({p2_den_r, 16'h0000});
  assign fin_num_nxt    = (p2_cmd_r == CMD_ABS2REL) ? p2_nsh_r : F_N_W'(p2_a_r);
  assign fin_den_nxt    = (p2_cmd_r == CMD_ABS2REL) ? p2_den_r : F_D_W'(p2_d_r);
  assign fin_sb_nxt.cmd   = p2_cmd_r;
  assign fin_sb_nxt.shift = p2_shift_r;
  assign fin_sb_nxt.sat   = fin_sat_nxt;

  hrc_div #(
    .N_W  (F_N_W),
    .D_W  (F_D_W),
    .Q_W  (F_Q_W),
    .SB_W ($bits(fdiv_sb_t))
  ) u_fdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p2_valid_r),
    .in_num    (fin_num_nxt),
    .in_den    (fin_den_nxt),
    .in_sb     (fin_sb_nxt),
    .out_valid (fq_valid),
    .out_quo   (fq),
    .out_sb    (fq_sb)
  );

  // final shift and saturation
  assign r0_nxt = fq >> fq_sb.shift;

  always_comb begin
    if (fq_sb.cmd == CMD_ABS2REL) begin
      out_nxt.saturated    = fq_sb.sat;
      out_nxt.humidity_out = fq_sb.sat ? OUT_MAX : fq[15:0];
    end else begin
      out_nxt.saturated    = |r0_nxt[F_Q_W-1:16];
      out_nxt.humidity_out = out_nxt.saturated ? OUT_MAX : r0_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // every accepted item gives its result a fixed time later
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("result missing at fixed latency");

  // saturated results carry the full-scale value
  a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> out_item.humidity_out == OUT_MAX)
    else $error("saturated result not at full scale");

  // exp mantissa stays in [1,2)
  a_mant_range : assert property (@(posedge clk) disable iff (!rst_n)
    e_valid |-> e_m[M_W-1])
    else $error("exp mantissa below one");

endmodule

### verif/tb.sv
// testbench for the humidity converter: directed and random items, predicted results checked
module tb;
  import hrc_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  out_item_t expected_q[$];
  int        n_fail = 0;
  int        n_sent = 0;
  int        n_seen = 0;
  int        n_sat = 0;
  int        burst_left = 0;

  // clock
  always #5 clk = ~clk;

  humidity_rel_abs_converter i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // floor shift of a signed value
  function automatic longint fshr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v + (longint'(1) << s) - 1) >>> s);
  endfunction

  // predict the converted humidity for one item
  function automatic out_item_t convert_humidity(in_item_t it);
    out_item_t res;
    longint t, x, y, k;
    longint unsigned f, z, p, d, a, r, den, num, lim, thr;
    int s;
    bit sat;
    t = it.temperature;
    x = (t * 64'sd1154744) / (64'sd62239 + t);
    y = fshr(x * 64'sd94548, 16);
    k = fshr(y, 16);
    f = y - k * 65536;
    z = (f * 64'd744261118) >> 16;
    p = 64'd1073741824;
    for (int n = 8; n >= 1; n--) p = 64'd1073741824 + ((p * z) >> 30) / n;
    d = 64'd69926 + t;
    s = 22 - int'(k);
    sat = 1'b0;
    if (it.cmd == CMD_REL2ABS) begin
      a = ((it.humidity_in * p) >> 16) * 64'd868005;
      r = (a / d) >> s;
      if (r > 65535) sat = 1'b1;
    end else begin
      den = (64'd868005 * p) >> 16;
      num = it.humidity_in * d;
      lim = den << 16;
      thr = (lim + ((64'd1 << s) - 1)) >> s;
      if (num >= thr) sat = 1'b1;
      else r = (num << s) / den;
    end
    res.humidity_out = sat ? OUT_MAX : r[15:0];
    res.saturated = sat;
    return res;
  endfunction

  // send one item, with bursts and gaps on the sender side
  task automatic send_item(logic cmd, logic [15:0] temp, logic [15:0] hum);
    in_item_t it;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    it.cmd = cmd;
    it.temperature = temp;
    it.humidity_in = hum;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(convert_humidity(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // check each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      n_seen++;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        n_fail++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_item.humidity_out !== exp_r.humidity_out) begin
          $error("humidity_out expected %0d actual %0d", exp_r.humidity_out,
                 out_item.humidity_out);
          n_fail++;
        end
        if (out_item.saturated !== exp_r.saturated) begin
          $error("saturated expected %0d actual %0d", exp_r.saturated, out_item.saturated);
          n_fail++;
        end
        if (out_item.saturated) n_sat++;
      end
    end
  end

  // corners of every field, both commands
  task automatic test_directed();
    logic [15:0] temps[6] = '{16'hD800, 16'h8000, 16'h0000, 16'h1900, 16'h7D00, 16'h7FFF};
    foreach (temps[i]) begin
      send_item(CMD_REL2ABS, temps[i], 16'h6400);
      send_item(CMD_ABS2REL, temps[i], 16'h0A00);
    end
    send_item(CMD_REL2ABS, 16'h1900, 16'h0000);
    send_item(CMD_ABS2REL, 16'h1900, 16'h0000);
    send_item(CMD_REL2ABS, 16'h7FFF, 16'hFFFF);
    send_item(CMD_ABS2REL, 16'h8000, 16'hFFFF);
    send_item(CMD_ABS2REL, 16'hD800, 16'h0001);
    send_item(CMD_REL2ABS, 16'hD800, 16'h0001);
  endtask

  // sender pauses until every result is back
  task automatic test_pause();
    drain_results();
    send_item(CMD_ABS2REL, 16'h1400, 16'h1000);
    drain_results();
  endtask

  // random items, mostly with temperatures from -40 to 125 in Q8
  task automatic test_random(int count);
    logic [15:0] temp, hum;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) temp = 16'($urandom());
      else temp = 16'($signed($urandom_range(0, 42240)) - 10240);
      case ($urandom_range(0, 3))
        0: hum = 16'($urandom());
        1: hum = 16'($urandom_range(0, 25600));
        2: hum = 16'($urandom_range(0, 12800));
        default: hum = 16'($urandom_range(0, 255));
      endcase
      send_item(1'($urandom()), temp, hum);
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pause();
    test_random(1250);
    drain_results();
    repeat (100) @(negedge clk);
    $display("sent %0d items, checked %0d results, %0d saturated", n_sent, n_seen, n_sat);
    if (n_fail == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule
